>>> hdl/voxsd_pkg.sv
// shared types, step numbers and the control store for the surface detector
// no dependencies
package voxsd_pkg;

   localparam int CoordW = 5;
   localparam int SizeW  = 6;

   // register indexes on the csr port
   localparam logic [1:0] REG_SIZE_X = 2'd0;
   localparam logic [1:0] REG_SIZE_Y = 2'd1;
   localparam logic [1:0] REG_SIZE_Z = 2'd2;

   typedef logic [3:0] pc_type;

   localparam pc_type PC_CLEAR  = 4'd0;
   localparam pc_type PC_IDLE   = 4'd1;
   localparam pc_type PC_QUERY  = 4'd2;   // first of nine probe steps
   localparam pc_type PC_QTAIL  = 4'd11;
   localparam pc_type PC_WREAD  = 4'd12;
   localparam pc_type PC_WWRITE = 4'd13;
   localparam pc_type PC_EMIT   = 4'd14;

   typedef enum logic [1:0] {
      OFF_ZERO,
      OFF_MINUS,
      OFF_PLUS
   } off_type;

   typedef enum logic [1:0] {
      COND_NEXT,
      COND_JUMP,
      COND_DISPATCH,
      COND_CLEAR
   } cond_type;

   typedef struct packed {
      logic     probe;
      off_type  dy;
      off_type  dz;
      logic     wr;
      logic     clr;
      logic     emit;
      cond_type cond;
      pc_type   target;
   } cw_type;

   typedef struct packed {
      logic accept;
      logic err;
      logic query;
      logic clr_last;
   } seq_stat_type;

   function automatic cw_type probe_word(off_type dy, off_type dz);
      cw_type w;
      w = '{probe: 1'b1, dy: dy, dz: dz, wr: 1'b0, clr: 1'b0, emit: 1'b0,
            cond: COND_NEXT, target: PC_IDLE};
      return w;
   endfunction

   function automatic cw_type rom_word(pc_type pc);
      cw_type w;
      w = '{probe: 1'b0, dy: OFF_ZERO, dz: OFF_ZERO, wr: 1'b0, clr: 1'b0,
            emit: 1'b0, cond: COND_JUMP, target: PC_IDLE};
      unique case (pc)
         PC_CLEAR: begin
            w.clr  = 1'b1;
            w.cond = COND_CLEAR;
         end
         PC_IDLE:            w.cond = COND_DISPATCH;
         PC_QUERY:           w = probe_word(OFF_ZERO,  OFF_ZERO);   // center row first
         PC_QUERY + 4'd1:    w = probe_word(OFF_MINUS, OFF_ZERO);
         PC_QUERY + 4'd2:    w = probe_word(OFF_PLUS,  OFF_ZERO);
         PC_QUERY + 4'd3:    w = probe_word(OFF_ZERO,  OFF_MINUS);
         PC_QUERY + 4'd4:    w = probe_word(OFF_MINUS, OFF_MINUS);
         PC_QUERY + 4'd5:    w = probe_word(OFF_PLUS,  OFF_MINUS);
         PC_QUERY + 4'd6:    w = probe_word(OFF_ZERO,  OFF_PLUS);
         PC_QUERY + 4'd7:    w = probe_word(OFF_MINUS, OFF_PLUS);
         PC_QUERY + 4'd8:    w = probe_word(OFF_PLUS,  OFF_PLUS);
         PC_QTAIL:           w.target = PC_EMIT;
         PC_WREAD:           w.cond = COND_NEXT;
         PC_WWRITE: begin
            w.wr   = 1'b1;
            w.cond = COND_NEXT;
         end
         PC_EMIT:            w.emit = 1'b1;
         default:            w.target = PC_IDLE;
      endcase
      return w;
   endfunction

endpackage

>>> hdl/voxel_surface_detect.sv
// top level of the voxel surface detector: occupancy row store and datapath
// depends on voxsd_pkg, voxsd_seq, voxsd_ram
//
//   channel  ports                                        transfer
//   req      start, busy, req_op, req_coord_*, req_fill   start high while busy low
//   rsp      rsp_valid, rsp_occupied, rsp_surface,        every cycle with rsp_valid
//            rsp_coord_error
//   csr      csr_write_en, csr_index, csr_wdata           every edge with write_en
//
// a query runs nine row reads through the single memory port, a step for the
// last read data, a result step and the dispatch step; a write reads the row,
// writes the row, then gives the result and returns to dispatch; a bad
// coordinate gives the result and returns to dispatch
// after reset the sequencer clears MAX_DIM*MAX_DIM rows, one per cycle, with
// busy high; csr writes are taken during that pass
// the receiver cannot stall: a result is shown for exactly one cycle
module voxel_surface_detect
   import voxsd_pkg::*;
#(
   parameter int MAX_DIM = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic              req_op,
   input  logic [CoordW-1:0] req_coord_x,
   input  logic [CoordW-1:0] req_coord_y,
   input  logic [CoordW-1:0] req_coord_z,
   input  logic              req_fill,
   output logic              rsp_valid,
   output logic              rsp_occupied,
   output logic              rsp_surface,
   output logic              rsp_coord_error,
   input  logic              csr_write_en,
   input  logic [1:0]        csr_index,
   input  logic [SizeW-1:0]  csr_wdata
);

   localparam int Depth = MAX_DIM * MAX_DIM;   // one word per x row
   localparam int AW    = $clog2(Depth);
   localparam int XW    = $clog2(MAX_DIM);

   // config registers
   logic [SizeW-1:0] size_x_ff, size_y_ff, size_z_ff;
   logic [SizeW-1:0] eff_x, eff_y, eff_z;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff <= SizeW'(32);
         size_y_ff <= SizeW'(32);
         size_z_ff <= SizeW'(32);
      end else if (csr_write_en) begin
         unique case (csr_index)
            REG_SIZE_X: size_x_ff <= csr_wdata;
            REG_SIZE_Y: size_y_ff <= csr_wdata;
            REG_SIZE_Z: size_z_ff <= csr_wdata;
            default: ;   // unmapped index is dropped
         endcase
      end
   end

   // sizes saturate at the store dimension
   assign eff_x = (int'(size_x_ff) > MAX_DIM) ? SizeW'(MAX_DIM) : size_x_ff;
   assign eff_y = (int'(size_y_ff) > MAX_DIM) ? SizeW'(MAX_DIM) : size_y_ff;
   assign eff_z = (int'(size_z_ff) > MAX_DIM) ? SizeW'(MAX_DIM) : size_z_ff;

   // sequencer
   cw_type       cw;
   seq_stat_type stat;
   logic         accept;
   logic         req_err;
   logic [AW-1:0] clr_ff;

   assign busy    = (cw.cond != COND_DISPATCH);
   assign accept  = start && !busy;
   assign req_err = !(({1'b0, req_coord_x} < eff_x) && ({1'b0, req_coord_y} < eff_y)
                      && ({1'b0, req_coord_z} < eff_z));

   assign stat = '{accept: accept, err: req_err, query: req_op,
                   clr_last: (clr_ff == AW'(Depth - 1))};

   voxsd_seq u_seq (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .cw    (cw)
   );

   // clearing pass row counter
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cw.clr) begin
         clr_ff <= clr_ff + AW'(1);
      end
   end

   // item registers, latched on the transfer
   logic [CoordW-1:0] x_ff, y_ff, z_ff;
   logic              fill_ff;
   logic              err_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         x_ff    <= req_coord_x;
         y_ff    <= req_coord_y;
         z_ff    <= req_coord_z;
         fill_ff <= req_fill;
         err_ff  <= req_err;
      end
   end

   // neighbour row address for the current step
   logic [SizeW-1:0] ny, nz;
   logic             y_out, z_out;
   logic [AW-1:0]    row_addr;

   always_comb begin
      ny    = {1'b0, y_ff};
      y_out = 1'b0;
      unique case (cw.dy)
         OFF_MINUS: begin
            ny    = {1'b0, y_ff} - SizeW'(1);
            y_out = (y_ff == '0);
         end
         OFF_PLUS: begin
            ny    = {1'b0, y_ff} + SizeW'(1);
            y_out = (ny >= eff_y);
         end
         default: ;
      endcase
      nz    = {1'b0, z_ff};
      z_out = 1'b0;
      unique case (cw.dz)
         OFF_MINUS: begin
            nz    = {1'b0, z_ff} - SizeW'(1);
            z_out = (z_ff == '0);
         end
         OFF_PLUS: begin
            nz    = {1'b0, z_ff} + SizeW'(1);
            z_out = (nz >= eff_z);
         end
         default: ;
      endcase
      row_addr = AW'(32'(nz) * 32'(MAX_DIM) + 32'(ny));
   end

   // row store
   logic [MAX_DIM-1:0] rd_row;
   logic [MAX_DIM-1:0] row_mod;
   logic [XW-1:0]      xi, xm, xp;

   assign xi = XW'(32'(x_ff));
   assign xm = XW'(32'(x_ff) - 32'd1);
   assign xp = XW'(32'(x_ff) + 32'd1);

   always_comb begin
      row_mod     = rd_row;
      row_mod[xi] = fill_ff;
   end

   voxsd_ram #(
      .WIDTH (MAX_DIM),
      .DEPTH (Depth)
   ) u_store (
      .clock (clock),
      .we    (cw.wr || cw.clr),
      .addr  (cw.clr ? clr_ff : row_addr),
      .wdata (cw.clr ? '0 : row_mod),
      .rdata (rd_row)
   );

   // probe tag, checked in the next cycle when the row arrives
   logic chk_ff, row_out_ff, center_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         chk_ff <= 1'b0;
      end else begin
         chk_ff <= cw.probe;
      end
      row_out_ff <= y_out || z_out;
      center_ff  <= (cw.dy == OFF_ZERO) && (cw.dz == OFF_ZERO);
   end

   // any outside or empty neighbour in this row marks a surface voxel
   logic left_out, right_out, hit;

   assign left_out  = (x_ff == '0);
   assign right_out = (({1'b0, x_ff} + SizeW'(1)) >= eff_x);
   assign hit = row_out_ff || left_out || right_out || !rd_row[xm] || !rd_row[xp]
                || (!center_ff && !rd_row[xi]);

   logic occ_ff, surf_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         occ_ff  <= 1'b0;
         surf_ff <= 1'b0;
      end else if (chk_ff) begin
         if (center_ff) begin
            occ_ff <= rd_row[xi];
         end
         if (hit) begin
            surf_ff <= 1'b1;
         end
      end
   end

   // result
   assign rsp_valid       = cw.emit;
   assign rsp_occupied    = occ_ff;
   assign rsp_surface     = occ_ff && surf_ff;
   assign rsp_coord_error = err_ff;

endmodule

>>> hdl/voxsd_ram.sv
// generic single-port ram with registered read
// no dependencies
module voxsd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

>>> hdl/voxsd_seq.sv
// microcode sequencer: step counter, control store and branch logic
// depends on voxsd_pkg
module voxsd_seq
   import voxsd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  seq_stat_type stat,
   output cw_type       cw
);

   pc_type pc_ff;
   pc_type pc_in;

   assign cw = rom_word(pc_ff);

   always_comb begin
      pc_in = pc_ff;
      unique case (cw.cond)
         COND_NEXT: pc_in = pc_ff + 4'd1;
         COND_JUMP: pc_in = cw.target;
         COND_DISPATCH: begin
            if (stat.accept) begin
               if (stat.err) begin
                  pc_in = PC_EMIT;
               end else if (stat.query) begin
                  pc_in = PC_QUERY;
               end else begin
                  pc_in = PC_WREAD;
               end
            end
         end
         COND_CLEAR: begin
            if (stat.clr_last) begin
               pc_in = cw.target;
            end
         end
         default: pc_in = PC_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= PC_CLEAR;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule
